[rtl/modexp_pkg.sv]
// shared constants for the modular exponentiation block
`default_nettype none

package modexp_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int DATA_W        = 32;
    localparam int CNT_W         = $clog2(OPERAND_WIDTH);
    localparam int CFG_INDEX_W   = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODULUS  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPONENT = 1'd1;

    localparam logic [OPERAND_WIDTH-1:0] MODULUS_RESET  = OPERAND_WIDTH'(2);
    localparam logic [OPERAND_WIDTH-1:0] MODULUS_MIN    = OPERAND_WIDTH'(2);
    localparam logic [OPERAND_WIDTH-1:0] EXPONENT_RESET = OPERAND_WIDTH'(1);
    localparam logic [OPERAND_WIDTH-1:0] OPND_ONE       = OPERAND_WIDTH'(1);

endpackage

`default_nettype wire

[rtl/modexp_base_if.sv]
// input channel carrying one base value per beat
`default_nettype none

interface modexp_base_if;
    import modexp_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] base;

    modport source (output valid, output base, input ready);
    modport sink   (input valid, input base, output ready);

endinterface

`default_nettype wire

[rtl/modexp_result_if.sv]
// output channel carrying one power_mod value per beat
`default_nettype none

interface modexp_result_if;
    import modexp_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] power_mod;

    modport source (output valid, output power_mod, input ready);
    modport sink   (input valid, input power_mod, output ready);

endinterface

`default_nettype wire

[rtl/modular_exponentiation_top.sv]
// modular exponentiation, right-to-left square-and-multiply on a shared shift-add-reduce unit
//
//  channel    dir  handshake      payload
//  base_ch    in   valid/ready    base      [31:0]
//  result_ch  out  valid/ready    power_mod [31:0]
//  cfg        in   cfg_we         cfg_index [0], cfg_data [31:0]
//
// per item, each of the 32 exponent bits takes a multiply when set and always a squaring,
// all on the modular multiplier, which handles one bit per cycle
// the base is first reduced by the same unit
// base_ch.ready is low from acceptance until the result is placed in the output register
// a result waiting on result_ch holds only the final transfer, not the next acceptance
// reset gives modulus 2 and exponent 1, no clearing pass
`default_nettype none

module modular_exponentiation_top (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire [modexp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire [modexp_pkg::DATA_W-1:0]        cfg_data,
    modexp_base_if.sink                         base_ch,
    modexp_result_if.source                     result_ch
);
    import modexp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_REDUCE = 6'b000010,
        S_NEXT   = 6'b000100,
        S_MUL    = 6'b001000,
        S_SQR    = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_WIDTH - 1);

    state_t                   state_reg, state_next;
    logic [OPERAND_WIDTH-1:0] modulus_reg, modulus_next;
    logic [OPERAND_WIDTH-1:0] exponent_reg, exponent_next;
    logic [OPERAND_WIDTH-1:0] prod_reg, prod_next;
    logic [OPERAND_WIDTH-1:0] x_reg, x_next;
    logic [OPERAND_WIDTH-1:0] y_reg, y_next;
    logic [OPERAND_WIDTH-1:0] acc_reg, acc_next;
    logic [OPERAND_WIDTH-1:0] sq_reg, sq_next;
    logic [OPERAND_WIDTH-1:0] exp_reg, exp_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         bit_cnt_reg, bit_cnt_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]        power_mod_reg, power_mod_next;

    logic [OPERAND_WIDTH+1:0] sum;
    logic [OPERAND_WIDTH+1:0] n1;
    logic [OPERAND_WIDTH+1:0] n2;
    logic [OPERAND_WIDTH-1:0] addend;
    logic [OPERAND_WIDTH-1:0] step_res;
    logic                     unit_last;
    logic                     in_beat;
    logic                     out_free;

    // config writes
    always_comb
    begin
        modulus_next  = modulus_reg;
        exponent_next = exponent_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODULUS:
                begin
                    if (cfg_data[OPERAND_WIDTH-1:0] >= MODULUS_MIN)
                    begin
                        modulus_next = cfg_data[OPERAND_WIDTH-1:0];
                    end
                end
                CFG_EXPONENT:
                begin
                    exponent_next = cfg_data[OPERAND_WIDTH-1:0];
                end
                default:
                begin
                    modulus_next  = modulus_reg;
                    exponent_next = exponent_reg;
                end
            endcase
        end
    end

    // shift-add-reduce step: prod = (2*prod + ybit*x) mod n, all inputs below n
    assign addend    = y_reg[OPERAND_WIDTH-1] ? x_reg : '0;
    assign sum       = {1'b0, prod_reg, 1'b0} + {2'b00, addend};
    assign n1        = {2'b00, modulus_reg};
    assign n2        = {1'b0, modulus_reg, 1'b0};
    assign unit_last = (cnt_reg == '0);

    always_comb
    begin
        if (sum >= n2)
        begin
            step_res = OPERAND_WIDTH'(sum - n2);
        end
        else if (sum >= n1)
        begin
            step_res = OPERAND_WIDTH'(sum - n1);
        end
        else
        begin
            step_res = sum[OPERAND_WIDTH-1:0];
        end
    end

    assign base_ch.ready       = (state_reg == S_IDLE);
    assign in_beat             = base_ch.valid && base_ch.ready;
    assign out_free            = !out_valid_reg || result_ch.ready;
    assign result_ch.valid     = out_valid_reg;
    assign result_ch.power_mod = power_mod_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        prod_next      = prod_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        exp_next       = exp_reg;
        cnt_next       = cnt_reg;
        bit_cnt_next   = bit_cnt_reg;
        power_mod_next = power_mod_reg;
        out_valid_next = out_valid_reg && !result_ch.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    // base mod n as 1 * base mod n
                    prod_next    = '0;
                    x_next       = OPND_ONE;
                    y_next       = base_ch.base[OPERAND_WIDTH-1:0];
                    cnt_next     = CNT_LAST;
                    acc_next     = OPND_ONE;
                    exp_next     = exponent_reg;
                    bit_cnt_next = CNT_LAST;
                    state_next   = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                prod_next = step_res;
                y_next    = y_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
                if (unit_last)
                begin
                    sq_next    = step_res;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                prod_next = '0;
                cnt_next  = CNT_LAST;
                y_next    = sq_reg;
                if (exp_reg[0])
                begin
                    x_next     = acc_reg;
                    state_next = S_MUL;
                end
                else
                begin
                    x_next     = sq_reg;
                    state_next = S_SQR;
                end
            end
            S_MUL:
            begin
                prod_next = step_res;
                y_next    = y_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
                if (unit_last)
                begin
                    acc_next   = step_res;
                    prod_next  = '0;
                    x_next     = sq_reg;
                    y_next     = sq_reg;
                    cnt_next   = CNT_LAST;
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                prod_next = step_res;
                y_next    = y_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
                if (unit_last)
                begin
                    sq_next      = step_res;
                    exp_next     = exp_reg >> 1;
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                    if (bit_cnt_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_NEXT;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    power_mod_next = DATA_W'(acc_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            modulus_reg   <= MODULUS_RESET;
            exponent_reg  <= EXPONENT_RESET;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            bit_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            modulus_reg   <= modulus_next;
            exponent_reg  <= exponent_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        acc_reg       <= acc_next;
        sq_reg        <= sq_next;
        exp_reg       <= exp_next;
        power_mod_reg <= power_mod_next;
    end

endmodule

`default_nettype wire

[rtl/modexp_checker.sv]
// port-level checks for the modular exponentiation block, bound to the top level
`default_nettype none

module modexp_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          in_valid,
    input wire                          in_ready,
    input wire                          out_valid,
    input wire                          out_ready,
    input wire [modexp_pkg::DATA_W-1:0] out_power_mod
);
    import modexp_pkg::*;

    // a result beat stays offered until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // a stalled result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_power_mod))
        else $error("stalled result changed");

    // an accepted base keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after a beat");

    // a new result only comes out of a busy block
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without work in progress");

endmodule

bind modular_exponentiation_top modexp_checker u_modexp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (base_ch.valid),
    .in_ready      (base_ch.ready),
    .out_valid     (result_ch.valid),
    .out_ready     (result_ch.ready),
    .out_power_mod (result_ch.power_mod)
);

`default_nettype wire
